// ----- rtl/core/sabr_pkg.sv -----
// shared types and constants for the signed alu
`default_nettype none
package sabr_pkg;
	localparam int WIDTH = 8;
	localparam int MAG_W = WIDTH + 1;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} op_t;

	// one request in flight through the iterative stages
	typedef struct packed {
		logic [2:0]       mode;
		logic [WIDTH-1:0] a;
		logic [WIDTH-1:0] b;
		logic [WIDTH-1:0] easy;      // add/sub result
		logic [MAG_W-1:0] rem;       // partial remainder
		logic [MAG_W-1:0] quo;       // dividend shifting into quotient
		logic [MAG_W-1:0] dvs;       // divisor magnitude
		logic [2*WIDTH:0] booth;     // booth accumulator {p, multiplier, q-1}
	} work_t;
endpackage
`default_nettype wire

// ----- rtl/core/signed_alu_booth_restoring_div.sv -----
// top level of the pipelined signed alu
// Signed two's complement ALU: add, subtract, Booth multiply (low bits kept),
// divide and remainder by restoring division on magnitudes. One request is
// accepted per cycle while in_stall is low; each result passes through one entry
// stage, WIDTH iteration stages each doing one Booth and one division step,
// and one output stage. Quotient truncates toward zero, the
// remainder takes the dividend's sign, a zero divisor gives 0 and sets
// divide_by_zero, and unused modes give 0. Stall freezes the whole pipe.
`default_nettype none
module signed_alu_booth_restoring_div (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire  [2:0]                 mode,
	input  wire  signed [sabr_pkg::WIDTH-1:0] operand_a,
	input  wire  signed [sabr_pkg::WIDTH-1:0] operand_b,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic signed [sabr_pkg::WIDTH-1:0] result,
	output logic                       divide_by_zero
);
	import sabr_pkg::*;

	localparam int NS = WIDTH + 1;

	work_t          pipe_s1 [NS];
	logic  [NS-1:0] vld_s1;
	work_t          nxt [NS];
	logic           adv;
	logic [WIDTH-1:0] ma, mb;
	work_t          ent;
	work_t          fin;
	logic [WIDTH-1:0] q, r, res_c;
	logic           dz_c;

	// whole pipe moves unless the output register is full and stalled
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_comb begin
		ma = operand_a[WIDTH-1] ? WIDTH'(-operand_a) : operand_a;
		mb = operand_b[WIDTH-1] ? WIDTH'(-operand_b) : operand_b;
		ent = '0;
		ent.mode = mode;
		ent.a = operand_a;
		ent.b = operand_b;
		case (mode)
			OP_ADD:  ent.easy = operand_a + operand_b;
			OP_SUB:  ent.easy = operand_a - operand_b;
			default: ent.easy = '0;
		endcase
		ent.rem = '0;
		// dividend sits at the top so WIDTH steps consume all of its bits
		ent.quo = {ma, 1'b0};
		ent.dvs = {1'b0, mb};
		ent.booth = {{WIDTH{1'b0}}, operand_b, 1'b0};
	end

	assign nxt[0] = ent;
	for (genvar i = 1; i < NS; i++) begin : g_st
		sabr_step u_step (.din(pipe_s1[i-1]), .dout(nxt[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= '0;
		end else if (adv) begin
			vld_s1 <= {vld_s1[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) pipe_s1[k] <= nxt[k];
		end
	end

	// sign fix and selection on the last stage
	always_comb begin
		fin = pipe_s1[NS-1];
		q = fin.quo[WIDTH-1:0];
		r = fin.rem[WIDTH-1:0];
		dz_c = 1'b0;
		case (fin.mode)
			OP_ADD, OP_SUB: res_c = fin.easy;
			OP_MUL: res_c = fin.booth[WIDTH:1];
			OP_DIV, OP_REM: begin
				if (fin.b == '0) begin
					dz_c = 1'b1;
					res_c = '0;
				end else if (fin.mode == OP_DIV) begin
					res_c = (fin.a[WIDTH-1] != fin.b[WIDTH-1]) ? WIDTH'(-q) : q;
				end else begin
					res_c = fin.a[WIDTH-1] ? WIDTH'(-r) : r;
				end
			end
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_s1[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result <= res_c;
			divide_by_zero <= dz_c;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("result changed under stall");
	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result == '0)
		else $error("nonzero result on zero divisor");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");
endmodule
`default_nettype wire

// ----- rtl/core/sabr_step.sv -----
// one stage: one booth step and one restoring division step
`default_nettype none
module sabr_step (
	input  wire  sabr_pkg::work_t din,
	output sabr_pkg::work_t       dout
);
	import sabr_pkg::*;

	logic [MAG_W-1:0] shifted;
	logic [MAG_W:0]   diff;
	logic [WIDTH-1:0] p;
	logic [WIDTH-1:0] psum;

	always_comb begin
		dout = din;
		// restoring division step
		shifted = {din.rem[MAG_W-2:0], din.quo[MAG_W-1]};
		diff = {1'b0, shifted} - {1'b0, din.dvs};
		dout.quo = {din.quo[MAG_W-2:0], ~diff[MAG_W]};
		dout.rem = diff[MAG_W] ? shifted : diff[MAG_W-1:0];
		// booth radix-2 step
		p = din.booth[2*WIDTH:WIDTH+1];
		case (din.booth[1:0])
			2'b01:   psum = p + din.a;
			2'b10:   psum = p - din.a;
			default: psum = p;
		endcase
		dout.booth = {psum[WIDTH-1], psum, din.booth[WIDTH:1]};
	end
endmodule
`default_nettype wire

// ----- verif/signed_alu_booth_restoring_div_tb.sv -----
// self-checking testbench for the pipelined signed alu
`timescale 1ns / 100ps
`default_nettype none
module signed_alu_booth_restoring_div_tb;
	import sabr_pkg::*;

	localparam int LATENCY = WIDTH + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int NUM_RANDOM = 1500;

	// one expected alu answer
	typedef struct {
		logic [WIDTH-1:0] value;
		logic             dz;
	} alu_answer_t;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [2:0]       mode;
	logic [WIDTH-1:0] operand_a;
	logic [WIDTH-1:0] operand_b;
	logic             out_valid;
	logic             out_stall;
	logic [WIDTH-1:0] result;
	logic             divide_by_zero;

	alu_answer_t answer_q[$];
	int          error_count;
	int          request_count;
	int          result_count;
	int          cycle_count;
	bit          hold_off;     // long receiver hold-off, asked by the pressure test
	bit          lazy_sender;  // allow random gaps on the request side
	bit          lazy_receiver;

	signed_alu_booth_restoring_div dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result         (result),
		.divide_by_zero (divide_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// magnitude of a two's complement word, one bit wider so the most negative fits
	function automatic logic [WIDTH:0] abs_value(logic [WIDTH-1:0] v);
		logic [WIDTH:0] wide;
		wide = {v[WIDTH-1], v};
		return v[WIDTH-1] ? -wide : wide;
	endfunction

	// predicted alu answer for one request
	function automatic alu_answer_t alu_predict(logic [2:0] op, logic [WIDTH-1:0] a,
			logic [WIDTH-1:0] b);
		alu_answer_t ans;
		logic [WIDTH:0] ma;
		logic [WIDTH:0] mb;
		logic [WIDTH:0] quot;
		logic [WIDTH:0] remd;
		ans.value = '0;
		ans.dz = 1'b0;
		case (op)
			OP_ADD: ans.value = a + b;
			OP_SUB: ans.value = a - b;
			OP_MUL: ans.value = a * b;
			OP_DIV, OP_REM: begin
				if (b == '0) begin
					ans.dz = 1'b1;
				end else begin
					ma = abs_value(a);
					mb = abs_value(b);
					quot = ma / mb;
					remd = ma % mb;
					if (op == OP_DIV)
						ans.value = (a[WIDTH-1] != b[WIDTH-1]) ? -quot[WIDTH-1:0] : quot[WIDTH-1:0];
					else
						ans.value = a[WIDTH-1] ? -remd[WIDTH-1:0] : remd[WIDTH-1:0];
				end
			end
			default: ans.value = '0;
		endcase
		return ans;
	endfunction

	// mostly short gaps, sometimes a long one
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// send one request; the payload stays put while stalled
	task automatic send_request(logic [2:0] op, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
		int gap;
		gap = lazy_sender ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= op;
		operand_a <= a;
		operand_b <= b;
		answer_q.push_back(alu_predict(op, a, b));
		request_count++;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// drop valid once a burst of requests is done
	task automatic go_quiet();
		in_valid <= 1'b0;
	endtask

	// wait until every answer has been checked, then let the pipe drain
	task automatic wait_drained();
		go_quiet();
		while (answer_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	// receiver stall pattern, also honors the pressure hold-off
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (lazy_receiver && $urandom_range(0, 3) == 0) begin
				gap = gap_length();
				out_stall <= 1'b1;
				repeat (gap > 0 ? gap - 1 : 0) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// result checker against the oldest expectation
	always @(posedge clk) begin
		alu_answer_t exp_ans;
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected result %0d dz %0b", $time, $signed(result),
					divide_by_zero);
				error_count++;
			end else begin
				exp_ans = answer_q.pop_front();
				if (result !== exp_ans.value) begin
					$display("%0t: result mismatch expected %0d actual %0d", $time,
						$signed(exp_ans.value), $signed(result));
					error_count++;
				end
				if (divide_by_zero !== exp_ans.dz) begin
					$display("%0t: divide_by_zero mismatch expected %0b actual %0b", $time,
						exp_ans.dz, divide_by_zero);
					error_count++;
				end
			end
		end
	end

	// operand extremes against every mode, plus unused modes
	task automatic test_directed();
		logic [WIDTH-1:0] corner[5];
		logic [2:0] op;
		corner = '{8'h80, 8'hff, 8'h00, 8'h01, 8'h7f};
		for (int m = 0; m < 8; m++) begin
			op = 3'(m);
			send_request(op, corner[m % 5], corner[(m + 2) % 5]);
		end
		// zero divisor for both division modes
		send_request(OP_DIV, 8'h55, 8'h00);
		send_request(OP_REM, 8'h80, 8'h00);
		// most negative over minus one wraps, remainder is zero
		send_request(OP_DIV, 8'h80, 8'hff);
		send_request(OP_REM, 8'h80, 8'hff);
		// most negative as divisor
		send_request(OP_DIV, 8'h80, 8'h80);
		send_request(OP_REM, 8'h7f, 8'h80);
		send_request(OP_DIV, 8'h81, 8'h80);
		// sign handling of truncation
		send_request(OP_DIV, 8'hf9, 8'h02);
		send_request(OP_REM, 8'hf9, 8'h02);
		send_request(OP_REM, 8'h07, 8'hfe);
		send_request(OP_MUL, 8'h80, 8'h80);
		send_request(OP_MUL, 8'h7f, 8'h7f);
		send_request(OP_ADD, 8'h7f, 8'h01);
		send_request(OP_SUB, 8'h80, 8'h01);
		wait_drained();
	endtask

	// random operations with random gaps on both sides
	task automatic test_random();
		logic [2:0] op;
		logic [WIDTH-1:0] a;
		logic [WIDTH-1:0] b;
		lazy_sender = 1'b1;
		lazy_receiver = 1'b1;
		for (int i = 0; i < NUM_RANDOM; i++) begin
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			a = WIDTH'($urandom);
			b = ($urandom_range(0, 15) == 0) ? '0 : WIDTH'($urandom);
			send_request(op, a, b);
		end
		wait_drained();
	endtask

	// long receiver hold-off while requests keep coming, so the pipe backs up
	task automatic test_backpressure();
		lazy_sender = 1'b0;
		lazy_receiver = 1'b0;
		hold_off = 1'b1;
		fork
			begin
				repeat (3 * LATENCY + 20) @(negedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 3 * LATENCY; i++)
				send_request(OP_DIV, WIDTH'($urandom), WIDTH'($urandom_range(1, 255)));
		join
		wait_drained();
	endtask

	initial begin
		error_count = 0;
		request_count = 0;
		result_count = 0;
		cycle_count = 0;
		hold_off = 1'b0;
		lazy_sender = 1'b0;
		lazy_receiver = 1'b0;
		in_valid = 1'b0;
		mode = '0;
		operand_a = '0;
		operand_b = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random();
		test_backpressure();

		$display("covered %0d requests and %0d results across all modes,", request_count,
			result_count);
		$display("with zero divisors, extreme operands, random gaps and a long stall");
		if (error_count == 0 && answer_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/sabr_pkg.sv
rtl/core/sabr_step.sv
rtl/core/signed_alu_booth_restoring_div.sv
verif/signed_alu_booth_restoring_div_tb.sv
